// ===== hdl/afilt_pkg.sv =====
// Shared types, constants and the step sequence of the altitude filter.
// No dependencies; every other file of the block imports this package.
package afilt_pkg;

   // Field and datapath widths
   localparam int DATA_W     = 32;
   localparam int DT_W       = 16;
   localparam int STATE_W    = 40;
   localparam int SUM_W      = STATE_W + 9;
   localparam int OPND_W     = 48;
   localparam int ACC_W      = 64;
   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 17;
   localparam int MUL_W      = MUL_A_W + MUL_B_W;
   localparam int ERR_W      = 34;
   localparam int STEP_W     = 5;
   localparam int CSR_ADDR_W = 4;

   localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

   // One g in Q16.16
   localparam logic signed [ERR_W-1:0] ONE_G_Q16 = 34'sd642689;

   // Register map (word index) and reset values
   localparam logic [1:0] REG_GAIN_POS = 2'd0;
   localparam logic [1:0] REG_GAIN_VEL = 2'd1;
   localparam logic [1:0] REG_GAIN_ACC = 2'd2;
   localparam logic [1:0] REG_REF_ALT  = 2'd3;

   localparam logic [DATA_W-1:0] RST_GAIN_POS = 32'd50331648;
   localparam logic [DATA_W-1:0] RST_GAIN_VEL = 32'd50331648;
   localparam logic [DATA_W-1:0] RST_GAIN_ACC = 32'd16777216;
   localparam logic [DATA_W-1:0] RST_REF_ALT  = 32'd0;

   // Multiplier operand selection
   localparam logic [2:0] MUL_NONE   = 3'd0;
   localparam logic [2:0] MUL_ERR_LO = 3'd1;
   localparam logic [2:0] MUL_ERR_HI = 3'd2;
   localparam logic [2:0] MUL_OP_HI  = 3'd3;
   localparam logic [2:0] MUL_OP_LO  = 3'd4;

   // Gain selection
   localparam logic [1:0] GAIN_K3 = 2'd0;
   localparam logic [1:0] GAIN_K2 = 2'd1;
   localparam logic [1:0] GAIN_K1 = 2'd2;

   // Accumulator operations
   localparam logic [2:0] ACC_NONE  = 3'd0;
   localparam logic [2:0] ACC_LD0   = 3'd1;
   localparam logic [2:0] ACC_ADD16 = 3'd2;
   localparam logic [2:0] ACC_LD24  = 3'd3;
   localparam logic [2:0] ACC_ADD0  = 3'd4;

   // Operand register loads
   localparam logic [1:0] OPND_NONE   = 2'd0;
   localparam logic [1:0] OPND_ACC16  = 2'd1;
   localparam logic [1:0] OPND_ACCSUM = 2'd2;
   localparam logic [1:0] OPND_MID    = 2'd3;

   // State register updates
   localparam logic [2:0] STORE_NONE  = 3'd0;
   localparam logic [2:0] STORE_ACORR = 3'd1;
   localparam logic [2:0] STORE_VEL   = 3'd2;
   localparam logic [2:0] STORE_PCORR = 3'd3;
   localparam logic [2:0] STORE_INC   = 3'd4;
   localparam logic [2:0] STORE_PBASE = 3'd5;
   localparam logic [2:0] STORE_FINAL = 3'd6;

   typedef struct packed {
      logic [2:0] mul_op;
      logic [1:0] gain_sel;
      logic [2:0] acc_op;
      logic [1:0] opnd_op;
      logic [2:0] store_op;
   } uop_type;

   localparam uop_type UOP_IDLE = '{MUL_NONE, GAIN_K3, ACC_NONE, OPND_NONE, STORE_NONE};

   typedef struct packed {
      logic    load;
      uop_type uop;
   } dp_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0]        gain_position;
      logic [DATA_W-1:0]        gain_velocity;
      logic [DATA_W-1:0]        gain_acceleration;
      logic signed [DATA_W-1:0] reference_altitude;
   } cfg_type;

   // Step sequence: three gain updates, then the two dt integrations.
   // Multiply, accumulate and store of neighboring steps overlap.
   function automatic uop_type step_uop(input logic [STEP_W-1:0] step);
      uop_type u;
      u = UOP_IDLE;
      unique case (step)
         5'd0:  begin u.mul_op = MUL_ERR_LO; u.gain_sel = GAIN_K3; end
         5'd1:  begin
            u.mul_op = MUL_ERR_HI; u.gain_sel = GAIN_K3; u.acc_op = ACC_LD0;
         end
         5'd2:  u.acc_op = ACC_ADD16;
         5'd3:  u.opnd_op = OPND_ACC16;
         5'd4:  u.mul_op = MUL_OP_HI;
         5'd5:  begin u.mul_op = MUL_OP_LO; u.acc_op = ACC_LD24; end
         5'd6:  u.acc_op = ACC_ADD0;
         5'd7:  begin
            u.store_op = STORE_ACORR; u.mul_op = MUL_ERR_LO; u.gain_sel = GAIN_K2;
         end
         5'd8:  begin
            u.mul_op = MUL_ERR_HI; u.gain_sel = GAIN_K2; u.acc_op = ACC_LD0;
         end
         5'd9:  u.acc_op = ACC_ADD16;
         5'd10: u.opnd_op = OPND_ACC16;
         5'd11: u.mul_op = MUL_OP_HI;
         5'd12: begin u.mul_op = MUL_OP_LO; u.acc_op = ACC_LD24; end
         5'd13: u.acc_op = ACC_ADD0;
         5'd14: begin
            u.store_op = STORE_VEL; u.mul_op = MUL_ERR_LO; u.gain_sel = GAIN_K1;
         end
         5'd15: begin
            u.mul_op = MUL_ERR_HI; u.gain_sel = GAIN_K1; u.acc_op = ACC_LD0;
         end
         5'd16: u.acc_op = ACC_ADD16;
         5'd17: u.opnd_op = OPND_ACC16;
         5'd18: u.mul_op = MUL_OP_HI;
         5'd19: begin u.mul_op = MUL_OP_LO; u.acc_op = ACC_LD24; end
         5'd20: u.acc_op = ACC_ADD0;
         5'd21: begin u.store_op = STORE_PCORR; u.opnd_op = OPND_ACCSUM; end
         5'd22: u.mul_op = MUL_OP_HI;
         5'd23: begin u.mul_op = MUL_OP_LO; u.acc_op = ACC_LD24; end
         5'd24: u.acc_op = ACC_ADD0;
         5'd25: u.store_op = STORE_INC;
         5'd26: u.opnd_op = OPND_MID;
         5'd27: u.mul_op = MUL_OP_HI;
         5'd28: begin u.mul_op = MUL_OP_LO; u.acc_op = ACC_LD24; end
         5'd29: u.acc_op = ACC_ADD0;
         5'd30: u.store_op = STORE_PBASE;
         5'd31: u.store_op = STORE_FINAL;
         default: u = UOP_IDLE;
      endcase
      return u;
   endfunction

endpackage

// ===== hdl/afilt_if.sv =====
// Request and response channel interfaces of the altitude filter.
// Depends on afilt_pkg for field widths.
interface afilt_req_if;
   import afilt_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] baro_altitude;
   logic signed [DATA_W-1:0] accel_down;
   logic [DT_W-1:0]          time_step;

   modport source(output valid, output baro_altitude, output accel_down,
                  output time_step, input ready);
   modport sink(input valid, input baro_altitude, input accel_down,
                input time_step, output ready);
endinterface

interface afilt_rsp_if;
   import afilt_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] altitude_out;
   logic signed [DATA_W-1:0] velocity_out;
   logic signed [DATA_W-1:0] accel_up_out;
   logic signed [DATA_W-1:0] altitude_error_out;

   modport source(output valid, output altitude_out, output velocity_out,
                  output accel_up_out, output altitude_error_out, input ready);
   modport sink(input valid, input altitude_out, input velocity_out,
                input accel_up_out, input altitude_error_out, output ready);
endinterface

// ===== hdl/afilt_csr.sv =====
// APB-style configuration registers: gains and reference altitude.
// Depends on afilt_pkg.
module afilt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [afilt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [afilt_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [afilt_pkg::DATA_W-1:0]     csr_prdata,
   output logic                            csr_pready,
   output afilt_pkg::cfg_type              cfg
);
   import afilt_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GAIN_POS: cfg_in.gain_position      = csr_pwdata;
            REG_GAIN_VEL: cfg_in.gain_velocity      = csr_pwdata;
            REG_GAIN_ACC: cfg_in.gain_acceleration  = csr_pwdata;
            REG_REF_ALT:  cfg_in.reference_altitude = $signed(csr_pwdata);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_position      <= RST_GAIN_POS;
         cfg_ff.gain_velocity      <= RST_GAIN_VEL;
         cfg_ff.gain_acceleration  <= RST_GAIN_ACC;
         cfg_ff.reference_altitude <= $signed(RST_REF_ALT);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         REG_GAIN_POS: csr_prdata = cfg_ff.gain_position;
         REG_GAIN_VEL: csr_prdata = cfg_ff.gain_velocity;
         REG_GAIN_ACC: csr_prdata = cfg_ff.gain_acceleration;
         REG_REF_ALT:  csr_prdata = cfg_ff.reference_altitude;
         default:      csr_prdata = '0;
      endcase
   end

endmodule

// ===== hdl/afilt_ctrl.sv =====
// Controller: accepts a request, walks the 32-step sequence, owns rsp valid.
// Depends on afilt_pkg (step sequence and command struct).
module afilt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output afilt_pkg::dp_cmd_type cmd
);
   import afilt_pkg::*;

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_RUN  = 1'b1;

   logic [0:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last;
   logic              stall;
   logic              exec;

   // Final step waits until the output register is free
   assign last      = (step_ff == LAST_STEP);
   assign stall     = last & rsp_valid_ff & ~rsp_ready;
   assign exec      = (state_ff == ST_RUN) & ~stall;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load = req_valid & req_ready;
   assign cmd.uop  = exec ? step_uop(step_ff) : UOP_IDLE;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (exec) begin
               if (last) begin
                  state_in = ST_IDLE;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // Output valid: set by the final step, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec & last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/afilt_dp.sv =====
// Datapath: filter state, shared 33x17 multiplier, 64-bit accumulator,
// saturating state adders and the output register. Depends on afilt_pkg.
module afilt_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  afilt_pkg::cfg_type              cfg,
   input  afilt_pkg::dp_cmd_type           cmd,
   input  logic signed [afilt_pkg::DATA_W-1:0] baro_altitude,
   input  logic signed [afilt_pkg::DATA_W-1:0] accel_down,
   input  logic [afilt_pkg::DT_W-1:0]          time_step,
   output logic signed [afilt_pkg::DATA_W-1:0] altitude_out,
   output logic signed [afilt_pkg::DATA_W-1:0] velocity_out,
   output logic signed [afilt_pkg::DATA_W-1:0] accel_up_out,
   output logic signed [afilt_pkg::DATA_W-1:0] altitude_error_out
);
   import afilt_pkg::*;

   // Clamp a 49-bit sum to the 40-bit state range
   function automatic logic signed [STATE_W-1:0] sat40(input logic signed [SUM_W-1:0] v);
      logic signed [STATE_W-1:0] r;
      if (v[SUM_W-1:STATE_W-1] == {(SUM_W-STATE_W+1){v[SUM_W-1]}}) begin
         r = v[STATE_W-1:0];
      end else begin
         r = v[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Clamp a 34-bit value to 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ERR_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[ERR_W-1:DATA_W-1] == {(ERR_W-DATA_W+1){v[ERR_W-1]}}) begin
         r = v[DATA_W-1:0];
      end else begin
         r = v[ERR_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Per-request registers
   logic signed [DATA_W-1:0]  err_ff, err_in;
   logic signed [DATA_W-1:0]  accel_up_ff, accel_up_in;
   logic [DT_W-1:0]           dt_ff;

   // Filter state, Q16.24
   logic signed [STATE_W-1:0] acorr_ff, acorr_in;
   logic signed [STATE_W-1:0] vel_ff, vel_in;
   logic signed [STATE_W-1:0] pcorr_ff, pcorr_in;
   logic signed [STATE_W-1:0] pbase_ff, pbase_in;
   logic signed [STATE_W-1:0] alt_ff, alt_in;

   // Working registers
   logic signed [STATE_W-1:0] inc_ff, inc_in;
   logic signed [OPND_W-1:0]  opnd_ff, opnd_in;
   logic signed [MUL_W-1:0]   mul_ff, mul_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   // Output register
   logic signed [DATA_W-1:0]  out_alt_ff, out_vel_ff, out_acc_ff, out_err_ff;

   logic [DATA_W-1:0]          gain;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [ACC_W-1:0]    mul_ext;
   logic signed [OPND_W-1:0]   acc16;
   logic signed [STATE_W-1:0]  store_base;
   logic signed [STATE_W-1:0]  store_sum;
   logic signed [STATE_W-1:0]  alt_sum;
   logic signed [STATE_W-1:0]  vel_sum;
   logic signed [STATE_W-1:0]  acc_sum;
   logic signed [STATE_W-1:0]  mid;

   // Error and gravity removal at request accept
   assign err_in = sat32(ERR_W'(baro_altitude) -
                         (ERR_W'($signed(alt_ff[STATE_W-1:8])) +
                          ERR_W'(cfg.reference_altitude)));
   assign accel_up_in = sat32(-(ERR_W'(accel_down) + ONE_G_Q16));

   // Gain select
   always_comb begin
      case (cmd.uop.gain_sel)
         GAIN_K3: gain = cfg.gain_acceleration;
         GAIN_K2: gain = cfg.gain_velocity;
         GAIN_K1: gain = cfg.gain_position;
         default: gain = cfg.gain_acceleration;
      endcase
   end

   // Multiplier operands: err by gain halves, operand halves by dt
   always_comb begin
      case (cmd.uop.mul_op)
         MUL_ERR_LO: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed({1'b0, gain[15:0]});
         end
         MUL_ERR_HI: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed({1'b0, gain[31:16]});
         end
         MUL_OP_HI: begin
            mul_a = MUL_A_W'($signed(opnd_ff[OPND_W-1:24]));
            mul_b = $signed({1'b0, dt_ff});
         end
         MUL_OP_LO: begin
            mul_a = $signed({{(MUL_A_W-24){1'b0}}, opnd_ff[23:0]});
            mul_b = $signed({1'b0, dt_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = MUL_W'(mul_a) * MUL_W'(mul_b);

   // Accumulator
   assign mul_ext = ACC_W'(mul_ff);
   always_comb begin
      case (cmd.uop.acc_op)
         ACC_LD0:   acc_in = mul_ext;
         ACC_ADD16: acc_in = acc_ff + (mul_ext <<< 16);
         ACC_LD24:  acc_in = mul_ext <<< 24;
         ACC_ADD0:  acc_in = acc_ff + mul_ext;
         default:   acc_in = acc_ff;
      endcase
   end

   assign acc16 = $signed(acc_ff[ACC_W-1:16]);

   // Operand register: scaled product, acceleration sum or midpoint velocity
   assign acc_sum = sat40(SUM_W'($signed({accel_up_ff, 8'h00})) + SUM_W'(acorr_ff));
   assign mid     = sat40(SUM_W'(vel_ff) + SUM_W'(inc_ff >>> 1));
   always_comb begin
      case (cmd.uop.opnd_op)
         OPND_ACC16:  opnd_in = acc16;
         OPND_ACCSUM: opnd_in = OPND_W'(acc_sum);
         OPND_MID:    opnd_in = OPND_W'(mid);
         default:     opnd_in = opnd_ff;
      endcase
   end

   // Shared saturating state adder
   always_comb begin
      case (cmd.uop.store_op)
         STORE_ACORR: store_base = acorr_ff;
         STORE_VEL:   store_base = vel_ff;
         STORE_PCORR: store_base = pcorr_ff;
         STORE_PBASE: store_base = pbase_ff;
         default:     store_base = acorr_ff;
      endcase
   end
   assign store_sum = sat40(SUM_W'(store_base) + SUM_W'(acc16));
   assign alt_sum   = sat40(SUM_W'(pbase_ff) + SUM_W'(pcorr_ff));
   assign vel_sum   = sat40(SUM_W'(vel_ff) + SUM_W'(inc_ff));

   // State updates
   always_comb begin
      acorr_in = acorr_ff;
      vel_in   = vel_ff;
      pcorr_in = pcorr_ff;
      pbase_in = pbase_ff;
      alt_in   = alt_ff;
      inc_in   = inc_ff;
      case (cmd.uop.store_op)
         STORE_ACORR: acorr_in = store_sum;
         STORE_VEL:   vel_in   = store_sum;
         STORE_PCORR: pcorr_in = store_sum;
         STORE_INC:   inc_in   = $signed(acc_ff[STATE_W+15:16]);
         STORE_PBASE: pbase_in = store_sum;
         STORE_FINAL: begin
            alt_in = alt_sum;
            vel_in = vel_sum;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acorr_ff <= '0;
         vel_ff   <= '0;
         pcorr_ff <= '0;
         pbase_ff <= '0;
         alt_ff   <= '0;
      end else begin
         acorr_ff <= acorr_in;
         vel_ff   <= vel_in;
         pcorr_ff <= pcorr_in;
         pbase_ff <= pbase_in;
         alt_ff   <= alt_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff      <= err_in;
         accel_up_ff <= accel_up_in;
         dt_ff       <= time_step;
      end
      if (cmd.uop.mul_op != MUL_NONE) begin
         mul_ff <= mul_in;
      end
      acc_ff  <= acc_in;
      opnd_ff <= opnd_in;
      inc_ff  <= inc_in;
      if (cmd.uop.store_op == STORE_FINAL) begin
         out_alt_ff <= $signed(alt_sum[STATE_W-1:8]);
         out_vel_ff <= $signed(vel_sum[STATE_W-1:8]);
         out_acc_ff <= accel_up_ff;
         out_err_ff <= err_ff;
      end
   end

   assign altitude_out       = out_alt_ff;
   assign velocity_out       = out_vel_ff;
   assign accel_up_out       = out_acc_ff;
   assign altitude_error_out = out_err_ff;

endmodule

// ===== hdl/third_order_altitude_filter.sv =====
// Third-order complementary altitude filter. Each request (baro altitude,
// down acceleration, time step) yields one response: altitude, vertical
// velocity, upward acceleration and altitude error, all Q16.16. A request
// is accepted and then walks the 32 steps of a sequencer that shares
// one 33x17 multiplier and a 64-bit accumulator across the three gain
// updates and the two time-step integrations. The next request is taken the
// cycle after a response is written to the output register; a response
// still waiting there holds the last step until it is taken.
// Depends on afilt_pkg, afilt_if, afilt_csr, afilt_ctrl and afilt_dp.
module third_order_altitude_filter (
   input  logic                             clock,
   input  logic                             reset,
   afilt_req_if.sink                        req_bus,
   afilt_rsp_if.source                      rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [afilt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [afilt_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [afilt_pkg::DATA_W-1:0]     csr_prdata,
   output logic                             csr_pready
);
   import afilt_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;

   // Configuration registers
   afilt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer
   afilt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // Arithmetic and state
   afilt_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .baro_altitude      (req_bus.baro_altitude),
      .accel_down         (req_bus.accel_down),
      .time_step          (req_bus.time_step),
      .altitude_out       (rsp_bus.altitude_out),
      .velocity_out       (rsp_bus.velocity_out),
      .accel_up_out       (rsp_bus.accel_up_out),
      .altitude_error_out (rsp_bus.altitude_error_out)
   );

endmodule

// ===== hdl/afilt_checker.sv =====
// Port-level assertions for the altitude filter, bound to the top level.
// Depends on afilt_pkg and third_order_altitude_filter.
module afilt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [afilt_pkg::DATA_W-1:0]     altitude_out,
   input logic [afilt_pkg::DATA_W-1:0]     velocity_out,
   input logic [afilt_pkg::DATA_W-1:0]     accel_up_out,
   input logic [afilt_pkg::DATA_W-1:0]     altitude_error_out
);
   import afilt_pkg::*;

   logic req_acc;
   assign req_acc = req_valid & req_ready;

   // Reset leaves no response pending and the input open
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state after reset not clean");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({altitude_out, velocity_out, accel_up_out, altitude_error_out}))
      else $error("stalled response changed");

   // One request in flight: input closes after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request accepted while busy");

   // No response appears right after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("response too early");

endmodule

bind third_order_altitude_filter afilt_checker u_afilt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .altitude_out       (rsp_bus.altitude_out),
   .velocity_out       (rsp_bus.velocity_out),
   .accel_up_out       (rsp_bus.accel_up_out),
   .altitude_error_out (rsp_bus.altitude_error_out)
);
